FILE: hdl/per_warp_instruction_buffer_top_defines.svh
// Assertion macros shared by the per-warp instruction buffer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PER_WARP_INSTRUCTION_BUFFER_TOP_DEFINES_SVH
`define PER_WARP_INSTRUCTION_BUFFER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PWIB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PWIB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

FILE: hdl/pwib_pkg.sv
// Shared types and constants of the per-warp instruction buffer.
// Depends on nothing; used by every module of the block.
package pwib_pkg;

    localparam int DEF_WARPS      = 4;
    localparam int DEF_DEPTH      = 2;
    localparam int DEF_INSTR_BITS = 64;

    localparam int OPCODE_W = 2;
    localparam int WARP_ID_W = 2;
    localparam int WORD_W = 64;
    localparam int ACTIVE_W = 3;

    localparam logic [OPCODE_W-1:0] OP_IDLE       = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_WRITE      = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ       = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_WRITE_READ = 2'd3;

    // Control fields of the item held in the input register.
    typedef struct packed {
        logic                 valid;
        logic [OPCODE_W-1:0]  opcode;
        logic [WARP_ID_W-1:0] warp_id;
    } pwib_issue_t;

endpackage

FILE: hdl/pwib_entry_ram.sv
// Instruction entry store: one write port, one registered read port.
// Depends on pwib_pkg for default sizes.
module pwib_entry_ram
    import pwib_pkg::*;
#(
    parameter int ENTRIES = DEF_WARPS * DEF_DEPTH,
    parameter int DW      = DEF_INSTR_BITS,
    parameter int AW      = $clog2(ENTRIES)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [ENTRIES];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // A read of the entry written at the same edge returns the new word.
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/pwib_ctrl.sv
// Per-warp fill and head tracking, bypass selection and the result register.
// Depends on pwib_pkg and the assertion macro header.
`include "per_warp_instruction_buffer_top_defines.svh"
module pwib_ctrl
    import pwib_pkg::*;
#(
    parameter int WARPS      = DEF_WARPS,
    parameter int DEPTH      = DEF_DEPTH,
    parameter int INSTR_BITS = DEF_INSTR_BITS,
    parameter int AW         = $clog2(WARPS * DEPTH)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pwib_issue_t           issue,
    input  logic [INSTR_BITS-1:0] issue_word,
    input  logic [WARP_ID_W-1:0]  la_warp,
    output logic                  ram_we,
    output logic [AW-1:0]         ram_waddr,
    output logic [INSTR_BITS-1:0] ram_wdata,
    output logic [AW-1:0]         ram_raddr,
    input  logic [INSTR_BITS-1:0] ram_rdata,
    output logic                  done,
    output logic [WORD_W-1:0]     instr_out,
    output logic                  warp_full,
    output logic                  warp_empty,
    output logic [ACTIVE_W-1:0]   active_warps,
    output logic                  write_dropped
);

    localparam int IDX_W = (WARPS > 1) ? $clog2(WARPS) : 1;
    localparam int FW    = $clog2(DEPTH + 1);
    localparam int HW    = $clog2(DEPTH);
    localparam int TW    = FW + 1;
    localparam int CW    = $clog2(WARPS + 1);

    logic [FW-1:0] fill_reg [WARPS];
    logic [HW-1:0] head_reg [WARPS];
    logic [CW-1:0] count_reg;
    logic [INSTR_BITS-1:0] hold_reg;
    logic done_reg;
    logic full_reg;
    logic empty_reg;
    logic dropped_reg;

    logic [IDX_W-1:0] idx;
    logic warp_ok;
    logic [FW-1:0] fill;
    logic [HW-1:0] head;
    logic was_empty;
    logic was_full;
    logic wr;
    logic rd;
    logic pass_through;
    logic pop;
    logic push;
    logic [FW-1:0] fill_after_pop;
    logic [TW-1:0] tail_sum;
    logic [HW-1:0] tail;
    logic [FW-1:0] fill_next;
    logic [HW-1:0] head_next;
    logic [CW-1:0] count_next;
    logic [INSTR_BITS-1:0] hold_next;
    logic full_next;
    logic empty_next;
    logic dropped_next;

    logic [IDX_W-1:0] la_idx;
    logic la_ok;
    logic [HW-1:0] la_head;

    always_comb
    begin
        idx = IDX_W'(issue.warp_id);
        warp_ok = (32'(issue.warp_id) < WARPS);
        fill = warp_ok ? fill_reg[idx] : '0;
        head = warp_ok ? head_reg[idx] : '0;
        was_empty = (fill == '0);
        was_full = (fill >= FW'(DEPTH));
        wr = issue.valid && warp_ok &&
             ((issue.opcode == OP_WRITE) || (issue.opcode == OP_WRITE_READ));
        rd = issue.valid && warp_ok &&
             ((issue.opcode == OP_READ) || (issue.opcode == OP_WRITE_READ));

        // A write and read of an empty warp hands the word straight out.
        pass_through = wr && rd && was_empty;
        pop = rd && !was_empty;
        push = wr && !was_full && !pass_through;
        dropped_next = wr && was_full;

        if (pop)
        begin
            head_next = (head == HW'(DEPTH - 1)) ? '0 : head + 1'b1;
        end
        else
        begin
            head_next = head;
        end
        fill_after_pop = fill - FW'(pop);

        // The tail sits below twice the depth, so one subtract wraps it.
        tail_sum = TW'(head_next) + TW'(fill_after_pop);
        if (tail_sum >= TW'(DEPTH))
        begin
            tail = HW'(tail_sum - TW'(DEPTH));
        end
        else
        begin
            tail = HW'(tail_sum);
        end
        fill_next = fill_after_pop + FW'(push);

        if (pop)
        begin
            hold_next = ram_rdata;
        end
        else if (pass_through || (push && was_empty))
        begin
            hold_next = issue_word;
        end
        else
        begin
            hold_next = hold_reg;
        end

        count_next = count_reg;
        if (issue.valid && warp_ok)
        begin
            if (was_empty && (fill_next != '0))
            begin
                count_next = count_reg + 1'b1;
            end
            else if (!was_empty && (fill_next == '0) && (count_reg != '0))
            begin
                count_next = count_reg - 1'b1;
            end
        end

        full_next = warp_ok && (fill_next >= FW'(DEPTH));
        empty_next = !warp_ok || (fill_next == '0);
    end

    assign ram_we = push;
    assign ram_waddr = AW'(AW'(idx) * AW'(DEPTH) + AW'(tail));
    assign ram_wdata = issue_word;

    // Read address for the next item, taking the head that the item now in
    // flight leaves behind when both address the same warp.
    always_comb
    begin
        la_idx = IDX_W'(la_warp);
        la_ok = (32'(la_warp) < WARPS);
        if (issue.valid && warp_ok && (issue.warp_id == la_warp))
        begin
            la_head = head_next;
        end
        else if (la_ok)
        begin
            la_head = head_reg[la_idx];
        end
        else
        begin
            la_head = '0;
        end
    end

    assign ram_raddr = AW'(AW'(la_idx) * AW'(DEPTH) + AW'(la_head));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WARPS; i++)
            begin
                fill_reg[i] <= '0;
                head_reg[i] <= '0;
            end
            count_reg <= '0;
            hold_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= issue.valid;
            if (issue.valid)
            begin
                hold_reg <= hold_next;
                count_reg <= count_next;
                if (warp_ok)
                begin
                    fill_reg[idx] <= fill_next;
                    head_reg[idx] <= head_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue.valid)
        begin
            full_reg <= full_next;
            empty_reg <= empty_next;
            dropped_reg <= dropped_next;
        end
    end

    assign done = done_reg;
    assign instr_out = WORD_W'(hold_reg);
    assign warp_full = full_reg;
    assign warp_empty = empty_reg;
    assign active_warps = ACTIVE_W'(count_reg);
    assign write_dropped = dropped_reg;

    `PWIB_ASSERT_NEXT(a_done_follows_issue, clk, rst_n, issue.valid, done_reg)
    `PWIB_ASSERT_NEXT(a_hold_when_no_issue, clk, rst_n, !issue.valid, $stable(hold_reg))
    `PWIB_ASSERT_NOW(a_flags_exclusive, clk, rst_n, done_reg, !(full_reg && empty_reg))
    `PWIB_ASSERT_NOW(a_drop_not_empty, clk, rst_n, done_reg && dropped_reg, !empty_reg)
    `PWIB_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, 32'(count_reg) <= WARPS)

endmodule

FILE: hdl/per_warp_instruction_buffer_top.sv
// Top level of the per-warp instruction buffer: input register, control and entry store.
// Depends on pwib_pkg, pwib_ctrl and pwib_entry_ram.
//
// Usage: the decode stage presents opcode, warp_id and instr_in with start
// high; the transfer completes at any rising edge where start is high and
// busy is low. busy is held low, so one transfer can complete every cycle.
// Each accepted item yields exactly one result. At the clock edge after
// the input transfer, done rises for one cycle while instr_out, warp_full,
// warp_empty, active_warps and write_dropped carry that item's result, and the
// result transfer completes at the edge that ends that cycle. The issue stage
// must take it in that cycle; it cannot stall the block.
// An item passes the input register, then the result register; throughput
// is one item per cycle. A read address for the entry store is formed as an
// item enters, using the head pointer that the item ahead of it leaves, so
// back-to-back items on the same warp see each other's updates.
// instr_out holds its value between items and after items that neither pop,
// pass a word through nor write an empty warp. Reset clears every fill count,
// head pointer, the non-empty warp count and instr_out; the entry store is not
// cleared and needs no clearing pass, since only written entries are ever read.
module per_warp_instruction_buffer_top
    import pwib_pkg::*;
#(
    parameter int WARPS      = DEF_WARPS,
    parameter int DEPTH      = DEF_DEPTH,
    parameter int INSTR_BITS = DEF_INSTR_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [OPCODE_W-1:0]  opcode,
    input  logic [WARP_ID_W-1:0] warp_id,
    input  logic [WORD_W-1:0]    instr_in,
    output logic                 done,
    output logic [WORD_W-1:0]    instr_out,
    output logic                 warp_full,
    output logic                 warp_empty,
    output logic [ACTIVE_W-1:0]  active_warps,
    output logic                 write_dropped
);

    localparam int ENTRIES = WARPS * DEPTH;
    localparam int AW      = $clog2(ENTRIES);

    // Input register: control fields and the kept part of the word.
    logic valid_reg;
    logic [OPCODE_W-1:0] opcode_reg;
    logic [WARP_ID_W-1:0] warp_id_reg;
    logic [INSTR_BITS-1:0] word_reg;
    pwib_issue_t issue;

    logic accept;
    logic ram_we;
    logic [AW-1:0] ram_waddr;
    logic [INSTR_BITS-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [INSTR_BITS-1:0] ram_rdata;

    // The block never refuses an item.
    assign busy = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    // Payload fields carry no reset; they are used only while valid is set.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            opcode_reg <= opcode;
            warp_id_reg <= warp_id;
            word_reg <= instr_in[INSTR_BITS-1:0];
        end
    end

    assign issue = '{valid: valid_reg, opcode: opcode_reg, warp_id: warp_id_reg};

    pwib_ctrl #(
        .WARPS      (WARPS),
        .DEPTH      (DEPTH),
        .INSTR_BITS (INSTR_BITS),
        .AW         (AW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .issue         (issue),
        .issue_word    (word_reg),
        .la_warp       (warp_id),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .done          (done),
        .instr_out     (instr_out),
        .warp_full     (warp_full),
        .warp_empty    (warp_empty),
        .active_warps  (active_warps),
        .write_dropped (write_dropped)
    );

    pwib_entry_ram #(
        .ENTRIES (ENTRIES),
        .DW      (INSTR_BITS),
        .AW      (AW)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
